[design/mfwi_pkg.sv]
// ----------------------------------------------------------------------------
// mfwi_pkg
// shared constants, command and status types of the money flow window indicator
// ----------------------------------------------------------------------------
package mfwi_pkg;

	// ring depth and derived widths
	localparam int WINDOW_DEPTH   = 1024;
	localparam int PTR_W          = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W          = $clog2(WINDOW_DEPTH + 1);

	// fixed field widths
	localparam int PRICE_W        = 32;
	localparam int VOL_W          = 32;
	localparam int FLOW_W         = 52;
	localparam int VALUE_W        = 64;
	localparam int WL_W           = 11;
	localparam int VSUM_W         = VOL_W + PTR_W;
	localparam int MFM_FRAC       = 16;
	localparam int MAG_W          = MFM_FRAC + 1;
	localparam int PROD_W         = MAG_W + VOL_W;
	localparam int STEP_W         = $clog2(VALUE_W + 1);
	localparam int DEFAULT_WINDOW = 20;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WLEN = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic diff;
		logic absval;
		logic cmp;
		logic dstep;
		logic mul;
		logic sign;
		logic write;
		logic sum_start;
		logic sum_step;
		logic qprep;
		logic qstep;
		logic qsign;
		logic clear;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic row_valid;
		logic last;
		logic held_zero;
		logic cnt_last;
		logic sum_done;
	} sts_t;

endpackage

[design/money_flow_window_indicator.sv]
// ----------------------------------------------------------------------------
// money_flow_window_indicator
// chaikin money flow / accumulation distribution over a series of price bars
// ----------------------------------------------------------------------------
//
//  channel  signals                                       flow control
//  -------  --------------------------------------------  -------------------
//  input    high/low/close_price, bar_volume, row_valid,  in_valid / in_stall
//           last_item
//  output   indicator_value, result_valid                 out_valid / out_stall
//  config   cfg_index, cfg_data                           cfg_valid / cfg_ready
//
//  a valid bar passes capture, difference, absolute value, compare, the 16-step
//  restoring divider that forms the money flow multiplier, the multiply, sign and
//  ring write; an invalid row ends after the difference step.
//  a last bar then loads its result once the output is free; in CMF mode it first
//  makes n ring reads (one read port), drains the read stage and runs the 64-step
//  restoring divider for the ratio.
//  reset clears the series and configuration at once; the rings need no clearing.
//  a waiting result does not block new bars; only the next result waits on out_stall.
//
module money_flow_window_indicator import mfwi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// bar input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PRICE_W-1:0]        high_price,
	input  logic [PRICE_W-1:0]        low_price,
	input  logic [PRICE_W-1:0]        close_price,
	input  logic [VOL_W-1:0]          bar_volume,
	input  logic                      row_valid,
	input  logic                      last_item,
	// result output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] indicator_value,
	output logic                      result_valid,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [WL_W-1:0]           cfg_data
);

	cmd_t               cmd;
	sts_t               sts;
	logic               busy;
	logic               mode_q;
	logic [WL_W-1:0]    wlen_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               rvalid_q;
	logic               out_free;
	logic [VALUE_W-1:0] res_value;
	logic               res_valid;

	// config writes are always taken; the user must write only while the block is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			wlen_q <= WL_W'(DEFAULT_WINDOW);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_WLEN: wlen_q <= cfg_data;
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// output register frees when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	mfwi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.mode     (mode_q),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	mfwi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode_q),
		.wlen        (wlen_q),
		.high_price  (high_price),
		.low_price   (low_price),
		.close_price (close_price),
		.bar_volume  (bar_volume),
		.row_valid   (row_valid),
		.last_item   (last_item),
		.sts         (sts),
		.res_value   (res_value),
		.res_valid   (res_valid)
	);

	// bars are taken only while the sequencer is idle
	assign in_stall = busy;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q  <= res_value;
			rvalid_q <= res_valid;
		end
	end

	assign out_valid       = out_valid_q;
	assign indicator_value = $signed(value_q);
	assign result_valid    = rvalid_q;

	// a bar request always leaves the sequencer busy for the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after bar request");

	// a new result never overwrites one still held by the consumer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && out_stall))
		else $error("pending result overwritten");

	// an empty series reports zero
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_valid) |-> (indicator_value == '0))
		else $error("null result with nonzero value");

	// a loaded result shows on the port next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

endmodule

[design/mfwi_ctrl.sv]
// ----------------------------------------------------------------------------
// mfwi_ctrl
// sequencer for per-bar multiplier, window summation and ratio division
// ----------------------------------------------------------------------------
module mfwi_ctrl import mfwi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_free,
	input  logic mode,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_DIFF  = 14'b00000000000010,
		S_ABS   = 14'b00000000000100,
		S_CMP   = 14'b00000000001000,
		S_DIV   = 14'b00000000010000,
		S_MUL   = 14'b00000000100000,
		S_SIGN  = 14'b00000001000000,
		S_WR    = 14'b00000010000000,
		S_WIN   = 14'b00000100000000,
		S_SUM   = 14'b00001000000000,
		S_QPREP = 14'b00010000000000,
		S_QDIV  = 14'b00100000000000,
		S_QSIGN = 14'b01000000000000,
		S_RES   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	// where to go once a bar is done
	function automatic state_t tail(input logic last, input logic held_zero, input logic md);
		state_t t;
		if (!last) begin
			t = S_IDLE;
		end else if (held_zero || md) begin
			t = S_RES;
		end else begin
			t = S_WIN;
		end
		return t;
	endfunction

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				if (sts.row_valid) begin
					state_d = S_ABS;
				end else begin
					state_d = tail(sts.last, sts.held_zero, mode);
				end
			end
			S_ABS: begin
				cmd.absval = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.dstep = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SIGN;
			end
			S_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = S_WR;
			end
			S_WR: begin
				// a bar is being written, so the series is never empty here
				cmd.write = 1'b1;
				state_d   = tail(sts.last, 1'b0, mode);
			end
			S_WIN: begin
				cmd.sum_start = 1'b1;
				state_d       = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_done) begin
					state_d = S_QPREP;
				end
			end
			S_QPREP: begin
				cmd.qprep = 1'b1;
				state_d   = S_QDIV;
			end
			S_QDIV: begin
				cmd.qstep = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_QSIGN;
				end
			end
			S_QSIGN: begin
				cmd.qsign = 1'b1;
				state_d   = S_RES;
			end
			S_RES: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/mfwi_dp.sv]
// ----------------------------------------------------------------------------
// mfwi_dp
// datapath: multiplier divider, flow product, bar rings, sums, ratio divider
// ----------------------------------------------------------------------------
module mfwi_dp import mfwi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                mode,
	input  logic [WL_W-1:0]     wlen,
	input  logic [PRICE_W-1:0]  high_price,
	input  logic [PRICE_W-1:0]  low_price,
	input  logic [PRICE_W-1:0]  close_price,
	input  logic [VOL_W-1:0]    bar_volume,
	input  logic                row_valid,
	input  logic                last_item,
	output sts_t                sts,
	output logic [VALUE_W-1:0]  res_value,
	output logic                res_valid
);

	localparam logic signed [VALUE_W-1:0] SMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] SMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	function automatic logic signed [VALUE_W-1:0] sat_add(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W-1:0] s;
		s = a + b;
		if ((a[VALUE_W-1] == b[VALUE_W-1]) && (s[VALUE_W-1] != a[VALUE_W-1])) begin
			s = b[VALUE_W-1] ? SMIN : SMAX;
		end
		return s;
	endfunction

	// captured bar
	logic [PRICE_W-1:0] high_q, low_q, close_q;
	logic [VOL_W-1:0]   vol_q;
	logic               row_q, last_q;

	// multiplier divider
	logic signed [PRICE_W+2:0] num_q;
	logic signed [PRICE_W:0]   den_q;
	logic [PRICE_W+1:0]        an_q;
	logic [PRICE_W-1:0]        ad_q;
	logic                      neg_q, zero_q, sat_q;
	logic [PRICE_W:0]          rem_q;
	logic [MFM_FRAC-1:0]       mq_q;
	logic [STEP_W-1:0]         cnt_q;

	// flow
	logic [PROD_W-1:0]         prod_q;
	logic signed [FLOW_W-1:0]  flow_q;

	// series state
	logic [PTR_W-1:0]          ptr_q;
	logic [CNT_W-1:0]          held_q;
	logic signed [VALUE_W-1:0] total_q;

	// rings
	logic signed [FLOW_W-1:0]  flow_mem [WINDOW_DEPTH];
	logic [VOL_W-1:0]          vol_mem  [WINDOW_DEPTH];

	// window summation
	logic [CNT_W-1:0]          k_q;
	logic                      pend_s1;
	logic signed [FLOW_W-1:0]  rd_flow_s1;
	logic [VOL_W-1:0]          rd_vol_s1;
	logic signed [VALUE_W-1:0] fsum_q;
	logic [VSUM_W-1:0]         vsum_q;

	// ratio divider
	logic [VALUE_W-1:0]        qmag_q;
	logic [VSUM_W:0]           qrem_q;
	logic                      qneg_q, qzero_q;
	logic [VALUE_W-1:0]        cmf_q;

	// combinational helpers
	logic signed [PRICE_W+2:0] num_neg;
	logic signed [PRICE_W:0]   den_neg;
	logic [PRICE_W:0]          rem_sh;
	logic                      rem_ge;
	logic [MAG_W-1:0]          mfm_mag;
	logic [31:0]               eff_w;
	logic [CNT_W-1:0]          eff_n, win_n;
	logic [CNT_W-1:0]          ptr_ext, addr_w;
	logic [PTR_W-1:0]          rd_addr;
	logic [VSUM_W:0]           qrem_sh;
	logic                      qrem_ge;
	logic [PTR_W-1:0]          ptr_nx;

	always_comb begin
		num_neg = -num_q;
		den_neg = -den_q;
		rem_sh  = {rem_q[PRICE_W-1:0], 1'b0};
		rem_ge  = (rem_sh >= {1'b0, ad_q});
		if (zero_q) begin
			mfm_mag = '0;
		end else if (sat_q) begin
			mfm_mag = {1'b1, {MFM_FRAC{1'b0}}};
		end else begin
			mfm_mag = {1'b0, mq_q};
		end

		eff_w = (wlen == '0) ? 32'(DEFAULT_WINDOW) : 32'(wlen);
		if (eff_w > 32'(WINDOW_DEPTH)) begin
			eff_w = 32'(WINDOW_DEPTH);
		end
		eff_n = eff_w[CNT_W-1:0];
		win_n = (eff_n > held_q) ? held_q : eff_n;

		ptr_ext = CNT_W'(ptr_q);
		if (ptr_ext >= k_q) begin
			addr_w = ptr_ext - k_q;
		end else begin
			addr_w = ptr_ext + CNT_W'(WINDOW_DEPTH) - k_q;
		end
		rd_addr = addr_w[PTR_W-1:0];

		ptr_nx = (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

		qrem_sh = {qrem_q[VSUM_W-1:0], qmag_q[VALUE_W-1]};
		qrem_ge = (qrem_sh >= {1'b0, vsum_q});
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			high_q  <= high_price;
			low_q   <= low_price;
			close_q <= close_price;
			vol_q   <= bar_volume;
			row_q   <= row_valid;
			last_q  <= last_item;
		end
		if (cmd.diff) begin
			num_q <= $signed({2'b00, close_q, 1'b0}) - $signed({3'b000, low_q})
				- $signed({3'b000, high_q});
			den_q <= $signed({1'b0, high_q}) - $signed({1'b0, low_q});
		end
		if (cmd.absval) begin
			an_q   <= num_q[PRICE_W+2] ? num_neg[PRICE_W+1:0] : num_q[PRICE_W+1:0];
			ad_q   <= den_q[PRICE_W] ? den_neg[PRICE_W-1:0] : den_q[PRICE_W-1:0];
			neg_q  <= num_q[PRICE_W+2] ^ den_q[PRICE_W];
			zero_q <= (den_q == '0);
		end
		if (cmd.cmp) begin
			sat_q <= (an_q >= {2'b00, ad_q});
			rem_q <= {1'b0, an_q[PRICE_W-1:0]};
			mq_q  <= '0;
		end
		if (cmd.dstep) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, ad_q}) : rem_sh;
			mq_q  <= {mq_q[MFM_FRAC-2:0], rem_ge};
		end
		if (cmd.mul) begin
			prod_q <= mfm_mag * vol_q;
		end
		if (cmd.sign) begin
			flow_q <= neg_q ? -$signed(FLOW_W'(prod_q)) : $signed(FLOW_W'(prod_q));
		end
		if (cmd.qprep) begin
			qzero_q <= (vsum_q == '0);
			qneg_q  <= fsum_q[VALUE_W-1];
			qmag_q  <= fsum_q[VALUE_W-1] ? VALUE_W'(-fsum_q) : VALUE_W'(fsum_q);
			qrem_q  <= '0;
		end
		if (cmd.qstep) begin
			qrem_q <= qrem_ge ? (qrem_sh - {1'b0, vsum_q}) : qrem_sh;
			qmag_q <= {qmag_q[VALUE_W-2:0], qrem_ge};
		end
		if (cmd.qsign) begin
			if (qzero_q) begin
				cmf_q <= '0;
			end else begin
				cmf_q <= qneg_q ? (~qmag_q + 1'b1) : qmag_q;
			end
		end
	end

	// bar rings
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			flow_mem[ptr_q] <= flow_q;
			vol_mem[ptr_q]  <= vol_q;
		end
		if (cmd.sum_step && (k_q != '0)) begin
			rd_flow_s1 <= flow_mem[rd_addr];
			rd_vol_s1  <= vol_mem[rd_addr];
		end
	end

	// series and sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			held_q  <= '0;
			total_q <= '0;
			fsum_q  <= '0;
			vsum_q  <= '0;
			k_q     <= '0;
			pend_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.cmp) begin
				cnt_q <= STEP_W'(MFM_FRAC);
			end else if (cmd.qprep) begin
				cnt_q <= STEP_W'(VALUE_W);
			end else if (cmd.dstep || cmd.qstep) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (cmd.write) begin
				ptr_q   <= ptr_nx;
				total_q <= sat_add(total_q, VALUE_W'(flow_q));
				if (held_q < CNT_W'(WINDOW_DEPTH)) begin
					held_q <= held_q + 1'b1;
				end
			end

			if (cmd.sum_start) begin
				k_q     <= win_n;
				fsum_q  <= '0;
				vsum_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.sum_step) begin
				if (k_q != '0) begin
					k_q     <= k_q - 1'b1;
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				if (pend_s1) begin
					fsum_q <= sat_add(fsum_q, VALUE_W'(rd_flow_s1));
					vsum_q <= vsum_q + VSUM_W'(rd_vol_s1);
				end
			end

			if (cmd.clear) begin
				ptr_q   <= '0;
				held_q  <= '0;
				total_q <= '0;
				fsum_q  <= '0;
				vsum_q  <= '0;
			end
		end
	end

	assign sts.row_valid = row_q;
	assign sts.last      = last_q;
	assign sts.held_zero = (held_q == '0);
	assign sts.cnt_last  = (cnt_q == STEP_W'(1));
	assign sts.sum_done  = (k_q == '0) && !pend_s1;

	assign res_valid = (held_q != '0);
	assign res_value = (held_q == '0) ? '0 : (mode ? VALUE_W'(total_q) : cmf_q);

endmodule
